// ----- design/stkv_pkg.sv -----
`default_nettype none

package stkv_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int KEY_BITS    = 32;
	localparam int VALUE_BITS  = 32;
	localparam int ADDR_BITS   = $clog2(TABLE_DEPTH);
	localparam int COUNT_BITS  = $clog2(TABLE_DEPTH + 1);
	localparam int ENTRY_BITS  = KEY_BITS + VALUE_BITS;

	typedef enum logic [1:0] {
		OP_GET = 2'd0,
		OP_SET = 2'd1,
		OP_DEL = 2'd2,
		OP_CLR = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_MISSING = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SRCH,
		S_CMP,
		S_ACT,
		S_SHIFT,
		S_PUT,
		S_DONE
	} state_t;

	typedef struct packed {
		op_t                   operation;
		logic [KEY_BITS-1:0]   lookup_key;
		logic [VALUE_BITS-1:0] new_value;
	} req_t;

	typedef struct packed {
		logic                  found;
		logic [VALUE_BITS-1:0] read_value;
		status_t               status;
		logic [COUNT_BITS-1:0] entry_count;
	} rsp_t;

endpackage

`default_nettype wire

// ----- design/stkv_ram.sv -----
`default_nettype none

module stkv_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- design/sorted_table_key_value_map.sv -----
`default_nettype none

// Channel  Direction  Handshake              Payload
// req      in         req_valid / req_ready  req_t: operation, lookup_key, new_value
// rsp      out        rsp_valid / rsp_ready  rsp_t: found, read_value, status, entry_count
//
// One item at a time; req_ready is high only while the sequencer is idle.
// Clear goes straight to the result state; a lookup runs one binary search step at a time,
// each a search state and a compare state (one RAM read port, registered read).
// Insert and delete then shift entries one at a time through the single entry RAM,
// reading each entry and writing it back one slot over (one write and one read port).
// Reset clears the state, entry count and result valid flag; the RAM needs no clearing pass.
// A result waiting on rsp_ready holds the sequencer in its final state.

module sorted_table_key_value_map
	import stkv_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_ready,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_ready,
	output rsp_t      rsp
);

	state_t                state_q, state_d;
	req_t                  req_q, req_d;
	logic [COUNT_BITS-1:0] count_q, count_d;
	logic [COUNT_BITS-1:0] lo_q, lo_d, hi_q, hi_d, pos_q, pos_d, mid_q, mid_d, n_q, n_d;
	logic [ADDR_BITS-1:0]  ptr_q, ptr_d, wptr_q, wptr_d;
	logic                  pend_q, pend_d;
	logic                  found_q, found_d;
	logic [VALUE_BITS-1:0] rdval_q, rdval_d;
	status_t               status_q, status_d;
	rsp_t                  rsp_q, rsp_d;
	logic                  rsp_valid_q, rsp_valid_d;

	logic                  ram_we, ram_re;
	logic [ADDR_BITS-1:0]  ram_waddr, ram_raddr;
	logic [ENTRY_BITS-1:0] ram_wdata, ram_rdata;
	logic [COUNT_BITS:0]   mid_sum;
	logic [COUNT_BITS-1:0] mid;
	logic [KEY_BITS-1:0]   rd_key;
	logic [VALUE_BITS-1:0] rd_val;
	logic                  shift_up;

	stkv_ram #(
		.WIDTH(ENTRY_BITS),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign mid_sum   = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid       = mid_sum[COUNT_BITS:1];
	assign rd_key    = ram_rdata[ENTRY_BITS-1:VALUE_BITS];
	assign rd_val    = ram_rdata[VALUE_BITS-1:0];
	assign shift_up  = (req_q.operation == OP_SET);
	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			pend_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			pend_q      <= pend_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		req_q    <= req_d;
		lo_q     <= lo_d;
		hi_q     <= hi_d;
		pos_q    <= pos_d;
		mid_q    <= mid_d;
		n_q      <= n_d;
		ptr_q    <= ptr_d;
		wptr_q   <= wptr_d;
		found_q  <= found_d;
		rdval_q  <= rdval_d;
		status_q <= status_d;
		rsp_q    <= rsp_d;
	end

	always_comb begin
		state_d     = state_q;
		req_d       = req_q;
		count_d     = count_q;
		lo_d        = lo_q;
		hi_d        = hi_q;
		pos_d       = pos_q;
		mid_d       = mid_q;
		n_d         = n_q;
		ptr_d       = ptr_q;
		wptr_d      = wptr_q;
		pend_d      = pend_q;
		found_d     = found_q;
		rdval_d     = rdval_q;
		status_d    = status_q;
		rsp_d       = rsp_q;
		rsp_valid_d = rsp_valid_q && !rsp_ready;
		ram_we      = 1'b0;
		ram_re      = 1'b0;
		ram_waddr   = wptr_q;
		ram_wdata   = ram_rdata;
		ram_raddr   = mid[ADDR_BITS-1:0];

		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					req_d    = req;
					found_d  = 1'b0;
					rdval_d  = '0;
					status_d = ST_OK;
					lo_d     = '0;
					hi_d     = count_q;
					if (req.operation == OP_CLR) begin
						count_d = '0;
						state_d = S_DONE;
					end else begin
						state_d = S_SRCH;
					end
				end
			end
			S_SRCH: begin
				if (lo_q < hi_q) begin
					ram_re  = 1'b1;
					mid_d   = mid;
					state_d = S_CMP;
				end else begin
					pos_d   = lo_q;
					state_d = S_ACT;
				end
			end
			S_CMP: begin
				if (rd_key == req_q.lookup_key) begin
					found_d = 1'b1;
					pos_d   = mid_q;
					if (req_q.operation == OP_GET) begin
						rdval_d = rd_val;
					end
					state_d = S_ACT;
				end else if (rd_key < req_q.lookup_key) begin
					lo_d    = mid_q + COUNT_BITS'(1);
					state_d = S_SRCH;
				end else begin
					hi_d    = mid_q;
					state_d = S_SRCH;
				end
			end
			S_ACT: begin
				state_d = S_DONE;
				pend_d  = 1'b0;
				case (req_q.operation)
					OP_SET: begin
						if (found_q) begin
							ram_we    = 1'b1;
							ram_waddr = pos_q[ADDR_BITS-1:0];
							ram_wdata = {req_q.lookup_key, req_q.new_value};
						end else if (count_q == COUNT_BITS'(TABLE_DEPTH)) begin
							status_d = ST_FULL;
						end else begin
							n_d     = count_q - pos_q;
							ptr_d   = ADDR_BITS'(count_q - COUNT_BITS'(1));
							state_d = S_SHIFT;
						end
					end
					OP_DEL: begin
						if (found_q) begin
							n_d     = count_q - pos_q - COUNT_BITS'(1);
							ptr_d   = ADDR_BITS'(pos_q + COUNT_BITS'(1));
							state_d = S_SHIFT;
						end else begin
							status_d = ST_MISSING;
						end
					end
					default: begin
						if (!found_q) begin
							status_d = ST_MISSING;
						end
					end
				endcase
			end
			S_SHIFT: begin
				if (pend_q) begin
					ram_we = 1'b1;
				end
				if (n_q != '0) begin
					ram_re    = 1'b1;
					ram_raddr = ptr_q;
					wptr_d    = shift_up ? ptr_q + ADDR_BITS'(1) : ptr_q - ADDR_BITS'(1);
					ptr_d     = shift_up ? ptr_q - ADDR_BITS'(1) : ptr_q + ADDR_BITS'(1);
					n_d       = n_q - COUNT_BITS'(1);
					pend_d    = 1'b1;
				end else begin
					pend_d = 1'b0;
					if (!pend_q) begin
						if (shift_up) begin
							state_d = S_PUT;
						end else begin
							count_d = count_q - COUNT_BITS'(1);
							state_d = S_DONE;
						end
					end
				end
			end
			S_PUT: begin
				ram_we    = 1'b1;
				ram_waddr = pos_q[ADDR_BITS-1:0];
				ram_wdata = {req_q.lookup_key, req_q.new_value};
				count_d   = count_q + COUNT_BITS'(1);
				state_d   = S_DONE;
			end
			S_DONE: begin
				if (!rsp_valid_q || rsp_ready) begin
					rsp_d.found       = found_q;
					rsp_d.read_value  = rdval_q;
					rsp_d.status      = status_q;
					rsp_d.entry_count = count_q;
					rsp_valid_d       = 1'b1;
					state_d           = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

`ifndef NO_ASSERTIONS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_BITS'(TABLE_DEPTH))
		else $error("entry count beyond table depth");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> (count_q == '0 ||
			count_q == $past(count_q) + COUNT_BITS'(1) ||
			count_q == $past(count_q) - COUNT_BITS'(1)))
		else $error("entry count moved by more than one");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE || state_q == S_DONE) |-> !ram_we)
		else $error("table write outside an operation");

	a_search_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMP) |-> (lo_q <= mid_q && mid_q < hi_q && hi_q <= count_q))
		else $error("search probe outside its window");
`endif

endmodule

`default_nettype wire

// ----- test/sorted_table_key_value_map_check.sv -----
`timescale 1ns / 100ps

module sorted_table_key_value_map_check
	import stkv_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	input  wire logic req_ready,
	input  wire req_t req,
	input  wire logic rsp_valid,
	input  wire logic rsp_ready,
	input  wire rsp_t rsp,
	output int        errors,
	output int        pending
);

	logic [KEY_BITS-1:0]   key_tab [TABLE_DEPTH];
	logic [VALUE_BITS-1:0] val_tab [TABLE_DEPTH];
	int                    used;
	rsp_t                  expected_replies [$];
	rsp_t                  want;

	task automatic apply_to_table(input req_t r, output rsp_t e);
		int lo;
		int hi;
		int mid;
		int pos;
		int i;
		bit hit;
		e = '0;
		e.status = ST_OK;
		if (r.operation == OP_CLR) begin
			used = 0;
		end else begin
			lo = 0;
			hi = used;
			hit = 1'b0;
			pos = 0;
			while (lo < hi && !hit) begin
				mid = lo + (hi - lo) / 2;
				if (key_tab[mid] == r.lookup_key) begin
					hit = 1'b1;
					pos = mid;
				end else if (key_tab[mid] < r.lookup_key) begin
					lo = mid + 1;
				end else begin
					hi = mid;
				end
			end
			if (!hit)
				pos = lo;
			e.found = hit;
			case (r.operation)
				OP_GET: begin
					if (hit)
						e.read_value = val_tab[pos];
					else
						e.status = ST_MISSING;
				end
				OP_SET: begin
					if (hit) begin
						val_tab[pos] = r.new_value;
					end else if (used >= TABLE_DEPTH) begin
						e.status = ST_FULL;
					end else begin
						for (i = used; i > pos; i--) begin
							key_tab[i] = key_tab[i-1];
							val_tab[i] = val_tab[i-1];
						end
						key_tab[pos] = r.lookup_key;
						val_tab[pos] = r.new_value;
						used++;
					end
				end
				default: begin
					if (hit) begin
						for (i = pos + 1; i < used; i++) begin
							key_tab[i-1] = key_tab[i];
							val_tab[i-1] = val_tab[i];
						end
						used--;
					end else begin
						e.status = ST_MISSING;
					end
				end
			endcase
		end
		e.entry_count = COUNT_BITS'(used);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used = 0;
			expected_replies.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (req_valid && req_ready) begin
				apply_to_table(req, want);
				expected_replies.push_back(want);
			end
			if (rsp_valid && rsp_ready) begin
				if (expected_replies.size() == 0) begin
					$error("result transfer with no request outstanding");
					errors = errors + 1;
				end else begin
					want = expected_replies.pop_front();
					if (rsp.found !== want.found) begin
						$error("found: expected %0d, got %0d", want.found, rsp.found);
						errors = errors + 1;
					end
					if (rsp.read_value !== want.read_value) begin
						$error("read_value: expected 'h%h, got 'h%h",
							want.read_value, rsp.read_value);
						errors = errors + 1;
					end
					if (rsp.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp.status);
						errors = errors + 1;
					end
					if (rsp.entry_count !== want.entry_count) begin
						$error("entry_count: expected %0d, got %0d",
							want.entry_count, rsp.entry_count);
						errors = errors + 1;
					end
				end
			end
			pending = expected_replies.size();
		end
	end

endmodule

// ----- test/sorted_table_key_value_map_tb.sv -----
`timescale 1ns / 100ps

module sorted_table_key_value_map_tb;
	import stkv_pkg::*;

	localparam int KEY_POOL = 80;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic rsp_ready = 1'b0;
	logic req_ready;
	logic rsp_valid;
	req_t req = '0;
	rsp_t rsp;
	int   errors;
	int   pending;
	int   idle_pct = 18;
	int   stall_pct = 81;
	bit   hold_req = 1'b0;

	logic [KEY_BITS-1:0] key_pool [KEY_POOL];

	sorted_table_key_value_map uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	sorted_table_key_value_map_check kv_check (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.errors(errors),
		.pending(pending)
	);

	always #1 clk = ~clk;

	initial begin
		#1_500_000;
		$display("CHECK FAILED");
		$finish;
	end

	task automatic send(op_t op, logic [KEY_BITS-1:0] key, logic [VALUE_BITS-1:0] value);
		while ($urandom_range(99) < idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req <= '{operation: op, lookup_key: key, new_value: value};
		while (!req_ready)
			@(negedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic random_items(int count, int set_w, int get_w);
		int   roll;
		op_t  op;
		logic [KEY_BITS-1:0] key;
		repeat (count) begin
			roll = $urandom_range(99);
			if ($urandom_range(149) == 0)
				op = OP_CLR;
			else if (roll < set_w)
				op = OP_SET;
			else if (roll < set_w + get_w)
				op = OP_GET;
			else
				op = OP_DEL;
			if ($urandom_range(9) == 0)
				key = $urandom;
			else
				key = key_pool[$urandom_range(KEY_POOL - 1)];
			send(op, key, $urandom);
		end
	endtask

	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				rsp_ready <= 1'b0;
				repeat (300) @(negedge clk);
				hold_req = 1'b0;
			end
			rsp_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	initial begin
		foreach (key_pool[i])
			key_pool[i] = $urandom;
		key_pool[0] = '0;
		key_pool[1] = '1;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send(OP_GET, 32'h0000_0000, 32'h0000_0000);
		send(OP_DEL, 32'h0000_0005, 32'hffff_ffff);
		send(OP_CLR, 32'hffff_ffff, 32'hffff_ffff);
		send(OP_SET, 32'h0000_0000, 32'h0000_0000);
		send(OP_SET, 32'hffff_ffff, 32'hffff_ffff);
		send(OP_SET, 32'h8000_0000, 32'ha5a5_a5a5);
		send(OP_SET, 32'h7fff_ffff, 32'h5a5a_5a5a);
		send(OP_GET, 32'h0000_0000, 32'hffff_ffff);
		send(OP_GET, 32'hffff_ffff, 32'h0000_0000);
		send(OP_GET, 32'h7fff_ffff, 32'h0000_0000);
		send(OP_GET, 32'h1234_5678, 32'h0000_0000);
		send(OP_SET, 32'h8000_0000, 32'h0000_0001);
		send(OP_GET, 32'h8000_0000, 32'h0000_0000);
		send(OP_DEL, 32'h0000_0000, 32'h0000_0000);
		send(OP_DEL, 32'hffff_ffff, 32'h0000_0000);
		send(OP_DEL, 32'h0000_0000, 32'h0000_0000);
		send(OP_GET, 32'h0000_0000, 32'h0000_0000);
		send(OP_SET, 32'h0000_0001, 32'hdead_beef);
		send(OP_DEL, 32'h8000_0000, 32'h0000_0000);
		send(OP_GET, 32'h7fff_ffff, 32'h0000_0000);
		send(OP_CLR, 32'h0000_0000, 32'h0000_0000);
		send(OP_GET, 32'h7fff_ffff, 32'h0000_0000);
		send(OP_DEL, 32'h0000_0001, 32'h0000_0000);

		send(OP_CLR, $urandom, $urandom);
		repeat (66) send(OP_SET, $urandom, $urandom);
		random_items(560, 60, 25);
		drain();

		idle_pct = 81;
		stall_pct = 18;
		random_items(640, 40, 30);
		drain();

		idle_pct = 0;
		stall_pct = 0;
		hold_req = 1'b1;
		random_items(620, 50, 30);
		drain();
		repeat (100) @(negedge clk);

		if (errors == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ----- filelist.f -----
design/stkv_pkg.sv
design/stkv_ram.sv
design/sorted_table_key_value_map.sv
test/sorted_table_key_value_map_check.sv
test/sorted_table_key_value_map_tb.sv
